// ===== rtl/sse_pkg.sv =====
// package: constants, calibration tables and control/status types
package sse_pkg;
	localparam int ON_TIME_ROWS  = 9;
	localparam int POSITION_COLS = 6;
	localparam int ROM_ROWS      = 9;
	localparam int ROM_COLS      = 6;
	localparam int ROW_BITS      = $clog2(ON_TIME_ROWS);
	localparam int COL_BITS      = $clog2(POSITION_COLS);

	localparam int REG_GAIN   = 0;
	localparam int REG_ON_MIN = 1;
	localparam int REG_ON_MAX = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	function automatic logic [9:0] volt_rom(input int r, input int c);
		logic [9:0] t [ROM_ROWS][ROM_COLS];
		int rr;
		int cc;
		t = '{
			'{10'd558, 10'd486, 10'd416, 10'd352, 10'd296, 10'd254},
			'{10'd555, 10'd484, 10'd412, 10'd349, 10'd290, 10'd248},
			'{10'd554, 10'd484, 10'd410, 10'd345, 10'd289, 10'd242},
			'{10'd553, 10'd482, 10'd411, 10'd345, 10'd282, 10'd234},
			'{10'd554, 10'd480, 10'd405, 10'd328, 10'd266, 10'd220},
			'{10'd550, 10'd468, 10'd382, 10'd306, 10'd242, 10'd203},
			'{10'd531, 10'd434, 10'd341, 10'd276, 10'd220, 10'd191},
			'{10'd460, 10'd367, 10'd290, 10'd223, 10'd180, 10'd164},
			'{10'd327, 10'd253, 10'd196, 10'd154, 10'd136, 10'd129}};
		rr = (r < ROM_ROWS) ? r : ROM_ROWS - 1;
		cc = (c < ROM_COLS) ? c : ROM_COLS - 1;
		return t[rr][cc];
	endfunction

	function automatic logic [14:0] pos_rom(input int c);
		logic [14:0] t [ROM_COLS];
		int cc;
		t = '{15'd0, 15'd4424, 15'd8233, 15'd12616, 15'd16630, 15'd20439};
		cc = (c < ROM_COLS) ? c : ROM_COLS - 1;
		return t[cc];
	endfunction

	function automatic logic [9:0] row_max(input int r);
		logic [9:0] m;
		m = '0;
		for (int c = 0; c < POSITION_COLS; c++)
			if (volt_rom(r, c) > m) m = volt_rom(r, c);
		return m;
	endfunction

	function automatic logic [9:0] row_min(input int r);
		logic [9:0] m;
		m = 10'd1023;
		for (int c = 0; c < POSITION_COLS; c++)
			if (volt_rom(r, c) < m) m = volt_rom(r, c);
		return m;
	endfunction

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_ROW, OP_BOUND, OP_CLAMP, OP_SEG, OP_DIVSTEP,
		OP_POS, OP_STEP, OP_FINISH
	} op_t;

	typedef struct packed {
		op_t            op;
		logic [COL_BITS-1:0] col;
	} cmd_t;

	typedef struct packed {
		logic seg_hit;
		logic seg_skip;
		logic div_done;
	} stat_t;
endpackage

// ===== rtl/sse_if.sv =====
// valid/ready channel interfaces for input and result items
interface sse_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] sample_on;
	logic [11:0] sample_off;
	logic [11:0] target_mv;
	modport source (output valid, sample_on, sample_off, target_mv, input ready);
	modport sink (input valid, sample_on, sample_off, target_mv, output ready);
endinterface

interface sse_out_if;
	logic        valid;
	logic        ready;
	logic [14:0] position_q12;
	logic [14:0] target_q12;
	logic [13:0] on_time_out;
	modport source (output valid, position_q12, target_q12, on_time_out, input ready);
	modport sink (input valid, position_q12, target_q12, on_time_out, output ready);
endinterface

// ===== rtl/sse_datapath.sv =====
// datapath: row interpolation, bound clamp, segment search, divider, controller step
module sse_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  sse_pkg::cmd_t       cmd,
	output sse_pkg::stat_t      stat,
	input  logic [11:0]         sample_on,
	input  logic [11:0]         sample_off,
	input  logic [11:0]         target_mv,
	input  logic [15:0]         gain_q8,
	input  logic [13:0]         on_time_min,
	input  logic [13:0]         on_time_max,
	output logic [14:0]         position_q12,
	output logic [14:0]         target_q12,
	output logic [13:0]         on_time_out
);
	// values scaled by 1000 (up to 4095 * 1000) fit in a 23-bit signed range; use 24
	logic [13:0] on_time_q;
	logic signed [12:0] vt_q;
	logic [11:0] tmv_q;
	logic [sse_pkg::ROW_BITS-1:0] xi_q;
	logic [10:0] frac_q;
	logic signed [23:0] vmax_q, vmin_q, a_q;
	logic [31:0] num_q;
	logic [23:0] den_q, rem_q;
	logic [14:0] d_q, pbase_q, quo_q;
	logic [5:0] dcnt_q;
	logic [14:0] pos_q;
	logic [14:0] tgt_q;
	logic signed [39:0] prod_q;
	logic seg_hit_q, seg_skip_q;

	// row value select
	logic [9:0] v0, v1, w0, w1, mx0, mx1, mn0, mn1;
	always_comb begin
		v0 = '0; v1 = '0; w0 = '0; w1 = '0; mx0 = '0; mx1 = '0; mn0 = '0; mn1 = '0;
		for (int r = 0; r < sse_pkg::ON_TIME_ROWS - 1; r++)
			if (xi_q == r[sse_pkg::ROW_BITS-1:0]) begin
				mx0 = sse_pkg::row_max(r); mx1 = sse_pkg::row_max(r + 1);
				mn0 = sse_pkg::row_min(r); mn1 = sse_pkg::row_min(r + 1);
				for (int c = 0; c < sse_pkg::POSITION_COLS - 1; c++)
					if (cmd.col == c[sse_pkg::COL_BITS-1:0]) begin
						v0 = sse_pkg::volt_rom(r, c);   v1 = sse_pkg::volt_rom(r + 1, c);
						w0 = sse_pkg::volt_rom(r, c+1); w1 = sse_pkg::volt_rom(r + 1, c+1);
					end
			end
	end
	logic [14:0] p0, p1;
	always_comb begin
		p0 = '0; p1 = '0;
		for (int c = 0; c < sse_pkg::POSITION_COLS - 1; c++)
			if (cmd.col == c[sse_pkg::COL_BITS-1:0]) begin
				p0 = sse_pkg::pos_rom(c); p1 = sse_pkg::pos_rom(c + 1);
			end
	end

	function automatic logic signed [23:0] lerp(input logic [9:0] a, input logic [9:0] b,
		input logic [10:0] f);
		logic signed [23:0] sa;
		logic signed [23:0] sb;
		logic signed [23:0] sf;
		sa = 24'(signed'({1'b0, a}));
		sb = 24'(signed'({1'b0, b}));
		sf = 24'(signed'({1'b0, f}));
		return sa * 24'sd1000 + sf * (sb - sa);
	endfunction

	// v/1000 for 0 <= v < 2^20: v * ceil(2^30/1000) >> 30 is exact there
	function automatic logic [12:0] div1000(input logic signed [23:0] v);
		logic [19:0] u;
		logic [40:0] p;
		u = v[19:0];
		p = 41'(u) * 41'd1073742;
		return 13'(p >> 30);
	endfunction

	logic signed [23:0] la, lb, dd, nn, vts;
	always_comb begin
		la = lerp(v0, v1, frac_q);
		lb = lerp(w0, w1, frac_q);
		vts = 24'(vt_q) * 24'sd1000;
		dd = lb - la;
		nn = vts - la;
		if (dd < 0) begin dd = -dd; nn = -nn; end
	end

	// row pair from on-time: x = on_time/1000 - 1, clamped to 0..7, by compare chain
	logic [sse_pkg::ROW_BITS-1:0] xr;
	logic [13:0] base;
	always_comb begin
		xr = '0;
		base = 14'd1000;
		for (int r = 1; r < sse_pkg::ON_TIME_ROWS - 1; r++)
			if (on_time_q >= 14'((r + 1) * 1000)) begin
				xr = r[sse_pkg::ROW_BITS-1:0];
				base = 14'((r + 1) * 1000);
			end
	end

	logic signed [15:0] err;
	logic signed [20:0] stp;
	logic signed [21:0] nxt;
	logic [23:0] rem_sh;
	assign err = signed'({1'b0, tgt_q}) - signed'({1'b0, pos_q});
	assign stp = (prod_q < 0) ? -21'((-prod_q) >>> 20) : 21'(prod_q >>> 20);
	assign nxt = 22'(signed'({1'b0, on_time_q})) + 22'(stp);
	assign rem_sh = {rem_q[22:0], num_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_time_q <= 14'd1000;
			seg_hit_q <= 1'b0;
			seg_skip_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			unique case (cmd.op)
				sse_pkg::OP_LOAD: begin
					vt_q <= 13'(signed'({1'b0, sample_on}) - signed'({1'b0, sample_off}));
					tmv_q <= target_mv;
				end
				sse_pkg::OP_ROW: begin
					xi_q <= xr;
					if (on_time_q < 14'd1000) frac_q <= '0;
					else if (on_time_q - base > 14'd1000) frac_q <= 11'd1000;
					else frac_q <= 11'(on_time_q - base);
					// target: tmv*16384/3300 = tmv*ceil(2^34/825) >> 22, exact over 12 bits
					tgt_q <= 15'((37'(tmv_q) * 37'd20824084) >> 22);
				end
				sse_pkg::OP_BOUND: begin
					vmax_q <= lerp(mx0, mx1, frac_q);
					vmin_q <= lerp(mn0, mn1, frac_q);
				end
				sse_pkg::OP_CLAMP: begin
					if (vts > vmax_q) vt_q <= div1000(vmax_q);
					else if (vts < vmin_q) vt_q <= div1000(vmin_q);
					pos_q <= sse_pkg::pos_rom(sse_pkg::POSITION_COLS - 1);
				end
				sse_pkg::OP_SEG: begin
					a_q <= la;
					seg_skip_q <= (dd == 0);
					seg_hit_q <= (dd != 0) && (nn >= 0) && (nn <= dd);
					num_q <= 32'(nn);
					den_q <= 24'(dd);
					d_q <= p1 - p0;
					pbase_q <= p0;
					dcnt_q <= '0;
				end
				sse_pkg::OP_DIVSTEP: begin
					// restoring divide of num*d by den; first multiply then 32 shift steps
					if (dcnt_q == 6'd0) begin
						num_q <= 32'(num_q[23:0]) * 32'(d_q);
						rem_q <= '0;
						dcnt_q <= 6'd1;
					end else begin
						num_q <= {num_q[30:0], 1'b0};
						if (rem_sh >= den_q) begin
							rem_q <= rem_sh - den_q;
							quo_q <= {quo_q[13:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[13:0], 1'b0};
						end
						dcnt_q <= dcnt_q + 6'd1;
					end
				end
				sse_pkg::OP_POS: pos_q <= pbase_q + quo_q;
				sse_pkg::OP_STEP: prod_q <= 40'(err) * 40'(signed'({1'b0, gain_q8}));
				sse_pkg::OP_FINISH: begin
					if (nxt > 22'(signed'({1'b0, on_time_max}))) on_time_q <= on_time_max;
					else if (nxt < 22'(signed'({1'b0, on_time_min}))) on_time_q <= on_time_min;
					else on_time_q <= 14'(nxt);
				end
				default: ;
			endcase
		end
	end

	assign stat.seg_hit = seg_hit_q;
	assign stat.seg_skip = seg_skip_q;
	assign stat.div_done = (dcnt_q == 6'd33);
	assign position_q12 = pos_q;
	assign target_q12 = tgt_q;
	assign on_time_out = on_time_q;
	logic unused;
	assign unused = ^a_q;
endmodule

// ===== rtl/sse_ctrl.sv =====
// controller: sequences load, bound clamp, column walk, divide and update
module sse_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output sse_pkg::cmd_t  cmd,
	input  sse_pkg::stat_t stat
);
	typedef enum logic [3:0] {
		S_IDLE, S_ROW, S_BOUND, S_CLAMP, S_SEG, S_CHK, S_DIV, S_POS, S_STEP, S_FIN, S_OUT
	} state_t;
	state_t state_q;
	logic [sse_pkg::COL_BITS-1:0] col_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd.col = col_q;
		unique case (state_q)
			S_IDLE:  cmd.op = in_valid ? sse_pkg::OP_LOAD : sse_pkg::OP_NONE;
			S_ROW:   cmd.op = sse_pkg::OP_ROW;
			S_BOUND: cmd.op = sse_pkg::OP_BOUND;
			S_CLAMP: cmd.op = sse_pkg::OP_CLAMP;
			S_SEG:   cmd.op = sse_pkg::OP_SEG;
			S_DIV:   cmd.op = stat.div_done ? sse_pkg::OP_NONE : sse_pkg::OP_DIVSTEP;
			S_POS:   cmd.op = sse_pkg::OP_POS;
			S_STEP:  cmd.op = sse_pkg::OP_STEP;
			S_FIN:   cmd.op = sse_pkg::OP_FINISH;
			default: cmd.op = sse_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_ROW;
				S_ROW:   state_q <= S_BOUND;
				S_BOUND: state_q <= S_CLAMP;
				S_CLAMP: begin col_q <= '0; state_q <= S_SEG; end
				S_SEG:   state_q <= S_CHK;
				S_CHK: begin
					if (stat.seg_hit) state_q <= S_DIV;
					else if (col_q == sse_pkg::COL_BITS'(sse_pkg::POSITION_COLS - 2))
						state_q <= S_STEP;
					else begin col_q <= col_q + 1'b1; state_q <= S_SEG; end
				end
				S_DIV:   if (stat.div_done) state_q <= S_POS;
				S_POS:   state_q <= S_STEP;
				S_STEP:  state_q <= S_FIN;
				S_FIN:   state_q <= S_OUT;
				S_OUT:   if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
	logic unused;
	assign unused = stat.seg_skip;
endmodule

// ===== rtl/solenoid_stroke_estimate_pcontrol_unit.sv =====
// top level: solenoid stroke estimator with proportional on-time control
// sequence: row select, bound, clamp, column walk (segment test and check per column),
//   segment divider (multiply, 32 shift steps, done), position, step, finish, result
// flow: one item at a time, next item taken in the cycle after the result is taken
// reset: arst_n async low; on-time 1000 us, gain 1280, limits 1000..9000
module solenoid_stroke_estimate_pcontrol_unit (
	input  logic clk,
	input  logic arst_n,
	sse_in_if.sink    in_ch,
	sse_out_if.source out_ch,
	input  logic                           cfg_we,
	input  logic [sse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sse_pkg::CFG_DATA_W-1:0] cfg_data
);
	logic [15:0] gain_q;
	logic [13:0] min_q, max_q;
	sse_pkg::cmd_t cmd;
	sse_pkg::stat_t stat;

	// configuration registers, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 16'd1280;
			min_q <= 14'd1000;
			max_q <= 14'd9000;
		end else if (cfg_we) begin
			if (cfg_index == sse_pkg::CFG_IDX_W'(sse_pkg::REG_GAIN)) gain_q <= cfg_data;
			else if (cfg_index == sse_pkg::CFG_IDX_W'(sse_pkg::REG_ON_MIN)) min_q <= cfg_data[13:0];
			else if (cfg_index == sse_pkg::CFG_IDX_W'(sse_pkg::REG_ON_MAX)) max_q <= cfg_data[13:0];
		end
	end

	sse_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd, .stat
	);

	// result registers hold while out valid waits
	sse_datapath u_dp (
		.clk, .arst_n, .cmd, .stat,
		.sample_on(in_ch.sample_on), .sample_off(in_ch.sample_off),
		.target_mv(in_ch.target_mv),
		.gain_q8(gain_q), .on_time_min(min_q), .on_time_max(max_q),
		.position_q12(out_ch.position_q12), .target_q12(out_ch.target_q12),
		.on_time_out(out_ch.on_time_out)
	);
endmodule

// ===== rtl/sse_checker.sv =====
// port checker for the top level, bound in
module sse_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [14:0] position_q12,
	input logic [13:0] on_time_out
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position_q12) && $stable(on_time_out))
		else $error("result dropped");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result too early");
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> position_q12 <= 15'd20439)
		else $error("position out of range");
endmodule

bind solenoid_stroke_estimate_pcontrol_unit sse_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.position_q12(out_ch.position_q12), .on_time_out(out_ch.on_time_out)
);

// ===== bench/tb.sv =====
// testbench for the solenoid stroke estimator with proportional on-time control
`timescale 1ns / 1ps

module tb;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [14:0] position_q12;
		logic [14:0] target_q12;
		logic [13:0] on_time_out;
	} stroke_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [sse_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [sse_pkg::CFG_DATA_W-1:0] cfg_data;

	sse_in_if in_ch ();
	sse_out_if out_ch ();

	solenoid_stroke_estimate_pcontrol_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// calibration curve, one row per 1000 us of on-time
	int cal_mv [9][6] = '{
		'{558, 486, 416, 352, 296, 254},
		'{555, 484, 412, 349, 290, 248},
		'{554, 484, 410, 345, 289, 242},
		'{553, 482, 411, 345, 282, 234},
		'{554, 480, 405, 328, 266, 220},
		'{550, 468, 382, 306, 242, 203},
		'{531, 434, 341, 276, 220, 191},
		'{460, 367, 290, 223, 180, 164},
		'{327, 253, 196, 154, 136, 129}};
	int cal_stroke [6] = '{0, 4424, 8233, 12616, 16630, 20439};

	// predictor state
	longint gain_q8, on_min, on_max, cur_on_time;
	stroke_res_t expected_results [$];

	int fail_count;
	int items_sent;
	int results_seen;
	int cycles;
	int send_idle_pct;
	int recv_idle_pct;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// row lookup with parameter overflow repeating the last row and column
	function automatic longint volt_at(input int r, input int c);
		return cal_mv[(r < 9) ? r : 8][(c < 6) ? c : 5];
	endfunction

	function automatic longint row_hi(input int r);
		longint m;
		m = 0;
		for (int c = 0; c < sse_pkg::POSITION_COLS; c++)
			if (volt_at(r, c) > m) m = volt_at(r, c);
		return m;
	endfunction

	function automatic longint row_lo(input int r);
		longint m;
		m = 1023;
		for (int c = 0; c < sse_pkg::POSITION_COLS; c++)
			if (volt_at(r, c) < m) m = volt_at(r, c);
		return m;
	endfunction

	// interpolated value scaled by 1000
	function automatic longint blend_k(input longint a, input longint b, input longint frac);
		return a * 1000 + frac * (b - a);
	endfunction

	// works out the result of one item and advances the kept on-time
	function automatic stroke_res_t predict_stroke(input logic [11:0] s_on,
			input logic [11:0] s_off, input logic [11:0] tmv);
		stroke_res_t res;
		longint vt, row, frac, vmax_s, vmin_s, vt_s, pos, tgt, step, nxt;
		longint a, b, num, den, d;
		bit found;
		vt = longint'(s_on) - longint'(s_off);
		row = cur_on_time / 1000 - 1;
		if (row < 0) row = 0;
		if (row > sse_pkg::ON_TIME_ROWS - 2) row = sse_pkg::ON_TIME_ROWS - 2;
		frac = cur_on_time - (row + 1) * 1000;
		if (frac < 0) frac = 0;
		if (frac > 1000) frac = 1000;
		vmax_s = blend_k(row_hi(row), row_hi(row + 1), frac);
		vmin_s = blend_k(row_lo(row), row_lo(row + 1), frac);
		// clamp to the interpolated bounds, max first
		if (vt * 1000 > vmax_s) vt = vmax_s / 1000;
		if (vt * 1000 < vmin_s) vt = vmin_s / 1000;
		vt_s = vt * 1000;
		found = 0;
		pos = cal_stroke[(sse_pkg::POSITION_COLS - 1 < 6) ? sse_pkg::POSITION_COLS - 1 : 5];
		for (int y = 0; y < sse_pkg::POSITION_COLS - 1; y++) begin
			if (!found) begin
				a = blend_k(volt_at(row, y), volt_at(row + 1, y), frac);
				b = blend_k(volt_at(row, y + 1), volt_at(row + 1, y + 1), frac);
				num = vt_s - a;
				den = b - a;
				if (den != 0) begin
					if (den < 0) begin
						num = -num;
						den = -den;
					end
					if (num >= 0 && num <= den) begin
						d = cal_stroke[(y + 1 < 6) ? y + 1 : 5] - cal_stroke[(y < 6) ? y : 5];
						pos = cal_stroke[(y < 6) ? y : 5] + (num * d) / den;
						found = 1;
					end
				end
			end
		end
		if (pos < 0) pos = 0;
		pos = pos & 32'h7FFF;
		tgt = (longint'(tmv) * 16384) / 3300;
		step = ((tgt - pos) * gain_q8) / 1048576;
		nxt = cur_on_time + step;
		if (nxt > on_max) nxt = on_max;
		else if (nxt < on_min) nxt = on_min;
		cur_on_time = nxt & 32'h3FFF;
		res.position_q12 = pos[14:0];
		res.target_q12 = tgt[14:0];
		res.on_time_out = cur_on_time[13:0];
		return res;
	endfunction

	// receiver: ready changes at the falling edge
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// result checker
	always @(posedge clk) begin
		stroke_res_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.position_q12 = out_ch.position_q12;
			got.target_q12 = out_ch.target_q12;
			got.on_time_out = out_ch.on_time_out;
			results_seen++;
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected: pos %0d tgt %0d on %0d", $time,
					got.position_q12, got.target_q12, got.on_time_out);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (got.position_q12 !== want.position_q12) begin
					$display("%0t: position_q12 expected %0d actual %0d", $time,
						want.position_q12, got.position_q12);
					fail_count++;
				end
				if (got.target_q12 !== want.target_q12) begin
					$display("%0t: target_q12 expected %0d actual %0d", $time,
						want.target_q12, got.target_q12);
					fail_count++;
				end
				if (got.on_time_out !== want.on_time_out) begin
					$display("%0t: on_time_out expected %0d actual %0d", $time,
						want.on_time_out, got.on_time_out);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// sends one item, called and returning at a falling edge
	task automatic send_item(input logic [11:0] s_on, input logic [11:0] s_off,
			input logic [11:0] tmv);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.sample_on = s_on;
		in_ch.sample_off = s_off;
		in_ch.target_mv = tmv;
		do
			@(posedge clk);
		while (!in_ch.ready);
		// item taken at this edge
		expected_results.push_back(predict_stroke(s_on, s_off, tmv));
		items_sent++;
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	// waits until every result is back and the datapath has settled
	task automatic wait_drained();
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input int idx, input logic [sse_pkg::CFG_DATA_W-1:0] value);
		cfg_we = 1'b1;
		cfg_index = idx[sse_pkg::CFG_IDX_W-1:0];
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			sse_pkg::REG_GAIN: gain_q8 = value;
			sse_pkg::REG_ON_MIN: on_min = value[13:0];
			sse_pkg::REG_ON_MAX: on_max = value[13:0];
			default: ; // unused index, ignored by the block
		endcase
	endtask

	// limits and gain straight after reset
	task automatic test_reset_defaults();
		send_item(12'd0, 12'd0, 12'd0);
		send_item(12'd3300, 12'd0, 12'd3300);
		send_item(12'd400, 12'd100, 12'd1650);
		wait_drained();
	endtask

	// field extremes, bound clamps and the ends of the on-time range
	task automatic test_directed_extremes();
		send_item(12'd0, 12'd3300, 12'd0);       // negative difference, clamped to min
		send_item(12'd4095, 12'd0, 12'd4095);    // all ones, clamped to max
		send_item(12'd0, 12'd4095, 12'd4095);
		send_item(12'd558, 12'd0, 12'd0);        // exact top of first row
		send_item(12'd254, 12'd0, 12'd3300);     // exact bottom of first row
		wait_drained();
		// large gain drives on-time to the top row and beyond the table
		write_reg(sse_pkg::REG_GAIN, 16'hFFFF);
		write_reg(sse_pkg::REG_ON_MAX, 16'h3FFF);
		write_reg(sse_pkg::REG_ON_MIN, 16'd0);
		for (int i = 0; i < 4; i++)
			send_item(12'd200, 12'd0, 12'd4095);
		for (int i = 0; i < 4; i++)
			send_item(12'd500, 12'd0, 12'd0);
		wait_drained();
		// min above max, gain zero, unused index
		write_reg(sse_pkg::REG_ON_MIN, 16'd9000);
		write_reg(sse_pkg::REG_ON_MAX, 16'd1000);
		send_item(12'd300, 12'd10, 12'd3300);
		send_item(12'd300, 12'd10, 12'd0);
		wait_drained();
		write_reg(sse_pkg::REG_GAIN, 16'd0);
		write_reg(3, 16'hFFFF);
		write_reg(sse_pkg::REG_ON_MIN, 16'd1000);
		write_reg(sse_pkg::REG_ON_MAX, 16'd9000);
		send_item(12'd350, 12'd20, 12'd2000);
		send_item(12'hFFF, 12'hFFF, 12'hFFF);
		wait_drained();
		write_reg(sse_pkg::REG_GAIN, 16'd1280);
	endtask

	task automatic random_config();
		case ($urandom_range(3))
			0: write_reg(sse_pkg::REG_GAIN, 16'($urandom));
			1: write_reg(sse_pkg::REG_GAIN, 16'($urandom_range(6000)));
			default: write_reg(sse_pkg::REG_GAIN, 16'($urandom_range(800, 2400)));
		endcase
		write_reg(sse_pkg::REG_ON_MIN, 16'($urandom_range(0, 3000)));
		write_reg(sse_pkg::REG_ON_MAX, 16'($urandom_range(5000, 9000)));
		if ($urandom_range(9) == 0) write_reg(sse_pkg::REG_ON_MAX, 16'($urandom));
		if ($urandom_range(9) == 0) write_reg(sse_pkg::REG_ON_MIN, 16'($urandom));
	endtask

	// mostly plausible coil readings, some full-range noise
	task automatic test_random_items(input int count);
		logic [11:0] s_on, s_off, tmv;
		int base;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) < 8) begin
				s_off = 12'($urandom_range(0, 2600));
				base = $urandom_range(80, 620);
				s_on = 12'(s_off + base);
				tmv = 12'($urandom_range(0, 3300));
			end else begin
				s_on = 12'($urandom);
				s_off = 12'($urandom);
				tmv = 12'($urandom);
			end
			send_item(s_on, s_off, tmv);
			if (i % 100 == 99) begin
				wait_drained();
				random_config();
			end
		end
		wait_drained();
	endtask

	initial begin
		fail_count = 0;
		items_sent = 0;
		results_seen = 0;
		cycles = 0;
		send_idle_pct = 9;
		recv_idle_pct = 74;
		gain_q8 = 1280;
		on_min = 1000;
		on_max = 9000;
		cur_on_time = 1000;
		in_ch.valid = 1'b0;
		in_ch.sample_on = '0;
		in_ch.sample_off = '0;
		in_ch.target_mv = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_directed_extremes();
		// sender mostly busy, receiver often stalled
		test_random_items(530);
		send_idle_pct = 74;
		recv_idle_pct = 9;
		test_random_items(530);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_items(540);

		$display("covered %0d items and %0d results over several gain and limit settings",
			items_sent, results_seen);
		$display("including min above max, zero and full gain, and on-times past the table");
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/sse_pkg.sv
rtl/sse_if.sv
rtl/sse_datapath.sv
rtl/sse_ctrl.sv
rtl/solenoid_stroke_estimate_pcontrol_unit.sv
rtl/sse_checker.sv
bench/tb.sv
